[rtl/core/pff_pkg.sv]
// Shared types, constants and sizing for the payload fragmenting framer.
`default_nettype none
package pff_pkg;

    localparam int FRAG_BYTES = 64;
    localparam int MAX_FRAGS  = 255;
    localparam int HDR_BYTES  = 8;

    localparam int LEN_W = 14;
    localparam int OFF_W = (FRAG_BYTES > 1) ? $clog2(FRAG_BYTES) : 1;
    localparam int IDX_W = 8;

    // Largest length that fits in MAX_FRAGS fragments.
    localparam int MAX_TOTAL = MAX_FRAGS * FRAG_BYTES;

    localparam logic [LEN_W-1:0] PSIZE_LEN = LEN_W'(FRAG_BYTES);

    localparam logic [7:0] DELIM_FIRST  = 8'hAB;
    localparam logic [7:0] DELIM_SECOND = 8'hCD;

    // Job queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Output sequencer steps: eight header bytes, then the payload byte.
    localparam int STEP_W = 4;
    typedef enum logic [STEP_W-1:0] {
        STEP_DELIM0  = 4'd0,
        STEP_DELIM1  = 4'd1,
        STEP_LEN_LO  = 4'd2,
        STEP_LEN_HI  = 4'd3,
        STEP_SLOT    = 4'd4,
        STEP_TYPE    = 4'd5,
        STEP_SEQ     = 4'd6,
        STEP_MORE    = 4'd7,
        STEP_PAYLOAD = 4'd8
    } t_step;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [7:0]       slot_number;
        logic [7:0]       frame_type;
        logic [LEN_W-1:0] total_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       fragment_end;
        logic       frame_end;
    } t_out_beat;

    typedef struct packed {
        logic             hdr;
        logic [7:0]       payload_byte;
        logic [7:0]       slot_number;
        logic [7:0]       frame_type;
        logic [15:0]      frag_len;
        logic [IDX_W-1:0] frag_idx;
        logic             more;
        logic             fragment_end;
        logic             frame_end;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

[rtl/core/pff_front.sv]
// Front end: accepts payload beats, tracks frame position, builds output jobs.
`default_nettype none
module pff_front
    import pff_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_beat  i_item,
    input  wire t_q_status i_q_stat,
    output logic           o_q_push,
    output t_job           o_job
);

    logic [LEN_W-1:0] r_pos,  n_pos;
    logic [LEN_W-1:0] r_base, n_base;
    logic [OFF_W-1:0] r_off,  n_off;
    logic [IDX_W-1:0] r_idx,  n_idx;

    logic             accept;
    logic             len_ok;
    logic             restart;
    logic [LEN_W-1:0] pos, base, remain, cur;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             frag_end;
    logic             frm_end;

    assign full   = i_q_stat.full;
    assign accept = push && !full;

    always_comb begin
        len_ok  = (i_item.total_length != '0) &&
                  (32'(i_item.total_length) <= 32'(MAX_TOTAL));
        restart = r_pos >= i_item.total_length;
        pos     = restart ? '0 : r_pos;
        base    = restart ? '0 : r_base;
        off     = restart ? '0 : r_off;
        idx     = restart ? '0 : r_idx;
        remain  = i_item.total_length - base;
        last    = remain <= PSIZE_LEN;
        cur     = last ? remain : PSIZE_LEN;
        frag_end = (LEN_W'(off) + LEN_W'(1)) == cur;
        frm_end  = (pos + LEN_W'(1)) == i_item.total_length;
    end

    always_comb begin
        o_q_push           = accept && len_ok;
        o_job.hdr          = (off == '0);
        o_job.payload_byte = i_item.payload_byte;
        o_job.slot_number  = i_item.slot_number;
        o_job.frame_type   = i_item.frame_type;
        o_job.frag_len     = 16'(HDR_BYTES) + 16'(cur);
        o_job.frag_idx     = idx;
        o_job.more         = !last;
        o_job.fragment_end = frag_end;
        o_job.frame_end    = frm_end;
    end

    always_comb begin
        n_pos  = r_pos;
        n_base = r_base;
        n_off  = r_off;
        n_idx  = r_idx;
        if (o_q_push) begin
            priority if (frm_end) begin
                n_pos  = '0;
                n_base = '0;
                n_off  = '0;
                n_idx  = '0;
            end else if (frag_end) begin
                n_pos  = pos + LEN_W'(1);
                n_base = base + PSIZE_LEN;
                n_off  = '0;
                n_idx  = idx + IDX_W'(1);
            end else begin
                n_pos  = pos + LEN_W'(1);
                n_base = base;
                n_off  = off + OFF_W'(1);
                n_idx  = idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_base <= '0;
            r_off  <= '0;
            r_idx  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_base <= n_base;
            r_off  <= n_off;
            r_idx  <= n_idx;
        end
    end

endmodule
`default_nettype wire

[rtl/core/pff_queue.sv]
// Small job queue decoupling the front end from the output sequencer.
`default_nettype none
module pff_queue
    import pff_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output t_job       o_job,
    output t_q_status  o_stat
);

    t_job            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wp, n_wp;
    logic [QA_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rp];

    always_comb begin
        do_push = i_push && !o_stat.full;
        do_pop  = i_pop && !o_stat.empty;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QA_W'(Q_DEPTH - 1)) ? '0 : r_wp + QA_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QA_W'(Q_DEPTH - 1)) ? '0 : r_rp + QA_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + QC_W'(1);
            2'b01:   n_cnt = r_cnt - QC_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[rtl/core/pff_back.sv]
// Back end: walks each job through header and payload bytes into the output register.
`default_nettype none
module pff_back
    import pff_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_job,
    input  wire t_q_status i_q_stat,
    output logic           o_q_pop,
    output logic           empty,
    input  wire logic      pop,
    output t_out_beat      o_result
);

    t_step             r_step, n_step;
    logic              r_valid, n_valid;
    t_out_beat         r_beat, n_beat;

    logic              advance;
    logic              have_job;
    t_step             step;

    assign empty    = !r_valid;
    assign o_result = r_beat;

    always_comb begin
        advance  = !r_valid || pop;
        have_job = !i_q_stat.empty;
        step     = i_job.hdr ? r_step : STEP_PAYLOAD;
        o_q_pop  = advance && have_job && (step == STEP_PAYLOAD);
    end

    always_comb begin
        n_beat.fragment_end = 1'b0;
        n_beat.frame_end    = 1'b0;
        unique case (step)
            STEP_DELIM0:  n_beat.out_byte = DELIM_FIRST;
            STEP_DELIM1:  n_beat.out_byte = DELIM_SECOND;
            STEP_LEN_LO:  n_beat.out_byte = i_job.frag_len[7:0];
            STEP_LEN_HI:  n_beat.out_byte = i_job.frag_len[15:8];
            STEP_SLOT:    n_beat.out_byte = i_job.slot_number;
            STEP_TYPE:    n_beat.out_byte = i_job.frame_type;
            STEP_SEQ:     n_beat.out_byte = 8'(i_job.frag_idx);
            STEP_MORE:    n_beat.out_byte = {7'd0, i_job.more};
            STEP_PAYLOAD: begin
                n_beat.out_byte     = i_job.payload_byte;
                n_beat.fragment_end = i_job.fragment_end;
                n_beat.frame_end    = i_job.frame_end;
            end
            default:      n_beat.out_byte = i_job.payload_byte;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (advance) begin
            n_valid = have_job;
            if (have_job) begin
                n_step = (step == STEP_PAYLOAD) ? STEP_DELIM0 :
                                                  t_step'(r_step + STEP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && have_job) begin
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_DELIM0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

endmodule
`default_nettype wire

[rtl/core/payload_fragmenting_framer_unit.sv]
// Top level of the payload fragmenting framer: front end, job queue, output sequencer.
//
//  channel  | handshake            | beat
//  ---------+----------------------+----------------------------------------
//  input    | push / full          | i_item   : t_in_beat  (one payload byte)
//  result   | empty / pop          | o_result : t_out_beat (one framed byte)
//
// One result beat leaves per cycle while pop is held and jobs are queued; a payload byte that starts a
// fragment gives nine beats (eight header bytes, then the byte), any other gives one.
// The output sequencer is the limit on throughput. Input beats are taken every cycle while
// the two-entry job queue has room. Synchronous reset clears the frame position, the
// queue, and the output sequencer's step and valid flag.
`default_nettype none
module payload_fragmenting_framer_unit
    import pff_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_beat i_item,
    output logic          empty,
    input  wire logic     pop,
    output t_out_beat     o_result
);

    t_q_status q_stat;
    t_job      push_job;
    t_job      head_job;
    logic      q_push;
    logic      q_pop;

    pff_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_q_push (q_push),
        .o_job    (push_job)
    );

    pff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    pff_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

[tb/tb_payload_fragmenting_framer_unit.sv]
// Self-checking testbench for payload_fragmenting_framer_unit: directed and random framed traffic vs. a predictor.
`default_nettype none
module tb_payload_fragmenting_framer_unit;
    import pff_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_in_beat beat;
        bit       drain;
    } t_pending;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    t_in_beat  i_item  = '0;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_beat o_result;

    payload_fragmenting_framer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_pending         feed_q[$];
    t_out_beat        framed_bytes[$];
    logic [LEN_W-1:0] frame_pos = '0;

    int tx_gap     = 0;
    int rx_gap     = 0;
    int rx_hold    = 0;
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;
    bit hold_done  = 1'b0;
    int n_taken    = 0;
    int n_beats    = 0;
    int n_errors   = 0;

    bit        tx_take;
    int        tx_next;
    int        rx_next;
    t_out_beat want;

    function automatic int next_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_framed(logic [7:0] b, logic frag_end, logic frm_end);
        t_out_beat o;
        o.out_byte     = b;
        o.fragment_end = frag_end;
        o.frame_end    = frm_end;
        framed_bytes.insert(framed_bytes.size(), o);
    endfunction

    // Predicts the framed bytes caused by one payload byte and advances the frame position.
    function automatic void frame_payload(t_in_beat b);
        int total, count, pos, idx, off, cur, flen;
        bit last;
        total = b.total_length;
        if (total == 0)
            return;
        count = (total + FRAG_BYTES - 1) / FRAG_BYTES;
        if (count > MAX_FRAGS)
            return;
        pos = frame_pos;
        if (pos >= total)
            pos = 0;
        idx  = pos / FRAG_BYTES;
        off  = pos % FRAG_BYTES;
        last = (idx == count - 1);
        cur  = last ? total - idx * FRAG_BYTES : FRAG_BYTES;
        if (off == 0) begin
            flen = HDR_BYTES + cur;
            add_framed(DELIM_FIRST, 1'b0, 1'b0);
            add_framed(DELIM_SECOND, 1'b0, 1'b0);
            add_framed(8'(flen), 1'b0, 1'b0);
            add_framed(8'(flen >> 8), 1'b0, 1'b0);
            add_framed(b.slot_number, 1'b0, 1'b0);
            add_framed(b.frame_type, 1'b0, 1'b0);
            add_framed(8'(idx), 1'b0, 1'b0);
            add_framed(last ? 8'd0 : 8'd1, 1'b0, 1'b0);
        end
        add_framed(b.payload_byte, off == cur - 1, pos == total - 1);
        pos++;
        if (pos >= total)
            pos = 0;
        frame_pos = LEN_W'(pos);
    endfunction

    function automatic void queue_item(logic [7:0] d, logic [7:0] s, logic [7:0] k, int len,
                                       bit drain);
        t_pending e;
        e.beat.payload_byte = d;
        e.beat.slot_number  = s;
        e.beat.frame_type   = k;
        e.beat.total_length = LEN_W'(len);
        e.drain             = drain;
        feed_q.insert(feed_q.size(), e);
    endfunction

    // Queues the first nbytes of a frame of length len with random content.
    function automatic void queue_frame(int len, int nbytes, bit drain_first);
        logic [7:0] s, k;
        s = 8'($urandom);
        k = 8'($urandom);
        for (int i = 0; i < nbytes; i++)
            queue_item(8'($urandom), s, k, len, drain_first && i == 0);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            i_item <= '0;
            tx_gap <= 0;
        end else begin
            tx_take = push && !full;
            tx_next = tx_gap;
            if (tx_take) begin
                frame_payload(i_item);
                void'(feed_q.pop_front());
                n_taken++;
                tx_next = next_gap(tx_burst);
                if ($urandom_range(0, 31) == 0)
                    tx_burst = !tx_burst;
            end
            if (push && !tx_take) begin
                // hold the beat until taken
            end else if (tx_next > 0) begin
                push   <= 1'b0;
                tx_gap <= tx_next - 1;
            end else if (feed_q.size() > 0 && (!feed_q[0].drain || framed_bytes.size() == 0)) begin
                push   <= 1'b1;
                i_item <= feed_q[0].beat;
                tx_gap <= 0;
            end else begin
                push   <= 1'b0;
                tx_gap <= 0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_beats++;
                if (framed_bytes.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 30)
                        $display("%0t: unexpected beat: got byte %02h frag_end %0b frame_end %0b",
                                 $time, o_result.out_byte, o_result.fragment_end,
                                 o_result.frame_end);
                end else begin
                    want = framed_bytes.pop_front();
                    if (o_result.out_byte !== want.out_byte ||
                        o_result.fragment_end !== want.fragment_end ||
                        o_result.frame_end !== want.frame_end) begin
                        n_errors++;
                        if (n_errors <= 30)
                            $display({"%0t: beat %0d mismatch: expected %02h/%0b/%0b, ",
                                      "got %02h/%0b/%0b (byte/frag_end/frame_end)"},
                                     $time, n_beats, want.out_byte, want.fragment_end,
                                     want.frame_end, o_result.out_byte,
                                     o_result.fragment_end, o_result.frame_end);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                pop     <= 1'b0;
            end else if (!hold_done && n_taken >= 40) begin
                // long stall so the input side backs up
                rx_hold   <= 300;
                hold_done <= 1'b1;
                pop       <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                pop    <= 1'b0;
            end else if (pop && !empty) begin
                rx_next = next_gap(rx_burst);
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                rx_gap <= (rx_next > 0) ? rx_next - 1 : 0;
                pop    <= (rx_next == 0);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int n, r, len, cut;
        bit drained;

        // directed
        queue_item(8'h00, 8'h00, 8'h00, 1, 1'b0);
        queue_item(8'hFF, 8'hFF, 8'hFF, 0, 1'b0);
        queue_item(8'h5A, 8'h12, 8'h34, 16383, 1'b0);
        queue_item(8'hA5, 8'h12, 8'h34, MAX_TOTAL + 1, 1'b0);
        queue_item(8'hFF, 8'hFF, 8'hFF, 2, 1'b0);
        queue_item(8'h00, 8'hFF, 8'hFF, 2, 1'b0);
        queue_item(8'h11, 8'h01, 8'h02, 3, 1'b0);
        queue_item(8'h22, 8'h01, 8'h02, 3, 1'b0);
        // shorter length mid-frame restarts the frame
        queue_item(8'h33, 8'h80, 8'h7F, 1, 1'b0);
        for (int i = 0; i < 3; i++)
            queue_item(8'(8'h40 + i), 8'h03, 8'h04, MAX_TOTAL, 1'b0);
        queue_item(8'h44, 8'h05, 8'h06, 2, 1'b0);
        queue_item(8'h55, 8'h05, 8'h06, 5, 1'b0);
        queue_item(8'h66, 8'h05, 8'h06, 5, 1'b0);
        queue_item(8'h77, 8'h05, 8'h06, 5, 1'b0);
        queue_item(8'h88, 8'h05, 8'h06, 5, 1'b0);
        queue_frame(FRAG_BYTES + 1, FRAG_BYTES + 1, 1'b1);

        // random
        n = 0;
        drained = 1'b0;
        while (n < 270) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                len = $urandom_range(1, 12);
            else if (r < 75)
                len = $urandom_range(13, 70);
            else if (r < 90)
                len = FRAG_BYTES * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
            else
                len = $urandom_range(129, 200);
            r = $urandom_range(0, 99);
            if (r < 82) begin
                queue_frame(len, len, !drained && n >= 140);
                drained = drained || n >= 140;
                n += len;
            end else if (r < 92) begin
                cut = $urandom_range(1, len);
                queue_frame(len, cut, 1'b0);
                n += cut;
            end else if (r < 96) begin
                queue_item(8'($urandom), 8'($urandom), 8'($urandom), 0, 1'b0);
            end else begin
                queue_item(8'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(MAX_TOTAL + 1, 16383), 1'b0);
            end
        end
        // start of a frame at the largest length
        queue_frame(MAX_TOTAL, 20, 1'b1);
        queue_frame(3, 3, 1'b0);

        @(posedge i_clk);
        @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || framed_bytes.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (n_errors == 0 && framed_bytes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
